@@ design/rgbads_pkg.sv @@
`default_nettype none

package rgbads_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = COL_W + 1;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CHAN_W     = 8;
    localparam int PAIR_W     = CHAN_W + 1;
    localparam int LINE_W     = 4 * PAIR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(480);

    // raster position of the pixel at the input
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              odd_col;
        logic              odd_row;
        logic              last_pair;
    } pos_t;

endpackage

`default_nettype wire

@@ design/rgbads_raster_ctrl.sv @@
`default_nettype none

module rgbads_raster_ctrl
    import rgbads_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  advance,
    output pos_t                       pos
);

    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    logic [WIDTH_W-1:0] eff_w;
    logic [ROW_W-1:0]   eff_h;
    logic [WIDTH_W-1:0] col_inc;
    logic [ROW_W:0]     row_inc;
    logic [WIDTH_W-1:0] last_col;
    logic [ROW_W:0]     last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one; clamp width to the line store
    always_comb begin
        if (width_reg == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    assign col_inc  = {1'b0, col_reg} + WIDTH_W'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    // an odd trailing column or row has no last pair; the all-ones result never matches
    assign last_col = {eff_w[WIDTH_W-1:1], 1'b0} - WIDTH_W'(1);
    assign last_row = {1'b0, eff_h[ROW_W-1:1], 1'b0} - (ROW_W+1)'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_inc >= eff_w) begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.slot      = col_reg[COL_W-1:1];
    assign pos.odd_col   = col_reg[0];
    assign pos.odd_row   = row_reg[0];
    assign pos.last_pair = ({1'b0, col_reg} == last_col) && ({1'b0, row_reg} == last_row);

endmodule

`default_nettype wire

@@ design/rgba_downscale_by_two_core.sv @@
`default_nettype none

// 2x2 box-filter downscaler for an 8-bit RGBA raster stream. Pixels enter in
// raster order at one per clock while s_ready is high; each output is the
// per-channel truncated average of a 2x2 block, so a frame of frame_width x
// frame_height gives frame_width/2 x frame_height/2 outputs, with a trailing
// odd column or row dropped. Sustained rate is one pixel per cycle while
// m_ready stays high; each output passes through the read of the 2048 x 36
// line store that keeps the pair sums of the upper row, held in the pending
// stage, and then the output register. Write
// cfg_index 0 (frame_width, 1..4096) or 1 (frame_height) only while the block
// is idle; a width of zero counts as one and a width above 4096 as 4096.
// m_last_of_frame marks the final output of each frame.
module rgba_downscale_by_two_core
    import rgbads_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAN_W-1:0]     s_channel_0,
    input  wire logic [CHAN_W-1:0]     s_channel_1,
    input  wire logic [CHAN_W-1:0]     s_channel_2,
    input  wire logic [CHAN_W-1:0]     s_channel_3,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CHAN_W-1:0]          m_avg_0,
    output logic [CHAN_W-1:0]          m_avg_1,
    output logic [CHAN_W-1:0]          m_avg_2,
    output logic [CHAN_W-1:0]          m_avg_3,
    output logic                       m_last_of_frame
);

    pos_t pos;
    logic accept;

    rgbads_raster_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .pos       (pos)
    );

    logic [4*CHAN_W-1:0] in_pix;
    logic [4*CHAN_W-1:0] held_reg;
    logic [LINE_W-1:0]   pair;
    logic                mem_wr_en;
    logic                mem_rd_en;

    logic [LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    logic              s1_valid_reg;
    logic [LINE_W-1:0] s1_pair_reg;
    logic              s1_last_reg;
    logic              s1_advance;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] avg_reg [4];
    logic              last_reg;
    logic [CHAN_W+1:0] blk_sum [4];

    logic out_free;

    assign in_pix = {s_channel_3, s_channel_2, s_channel_1, s_channel_0};

    assign out_free   = !out_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign accept     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (accept && !pos.odd_col) begin
            held_reg <= in_pix;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            pair[c*PAIR_W +: PAIR_W] = {1'b0, held_reg[c*CHAN_W +: CHAN_W]}
                                     + {1'b0, in_pix[c*CHAN_W +: CHAN_W]};
        end
    end

    // even rows store the pair sums, odd rows fetch the row above
    assign mem_wr_en = accept && pos.odd_col && !pos.odd_row;
    assign mem_rd_en = accept && pos.odd_col && pos.odd_row;

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            line_mem[pos.slot] <= pair;
        end
    end

    // hold read data while the stage stalls; no read is issued then
    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= line_mem[pos.slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= mem_rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            s1_pair_reg <= pair;
            s1_last_reg <= pos.last_pair;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            blk_sum[c] = {1'b0, rd_data_reg[c*PAIR_W +: PAIR_W]}
                       + {1'b0, s1_pair_reg[c*PAIR_W +: PAIR_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            for (int c = 0; c < 4; c++) begin
                avg_reg[c] <= blk_sum[c][CHAN_W+1:2];
            end
            last_reg <= s1_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_avg_0         = avg_reg[0];
    assign m_avg_1         = avg_reg[1];
    assign m_avg_2         = avg_reg[2];
    assign m_avg_3         = avg_reg[3];
    assign m_last_of_frame = last_reg;

`ifndef ASSERT_OFF
    a_rd_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_rd_en && mem_wr_en))
        else $error("line store read and write in the same cycle");

    a_rd_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd_en |=> s1_valid_reg)
        else $error("line store read did not load the pending stage");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_s1_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> out_valid_reg)
        else $error("pending request did not reach the output register");
`endif

endmodule

`default_nettype wire

@@ tb/tb_rgba_downscale_by_two_core.sv @@
`default_nettype none

module tb_rgba_downscale_by_two_core
    import rgbads_pkg::*;
();

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef logic [3:0][CHAN_W-1:0] pixel_t;
    typedef struct packed {
        pixel_t avg;
        logic   last;
    } block_avg_t;

    typedef enum {RX_STREAM, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CHAN_W-1:0]     s_channel_0 = '0;
    logic [CHAN_W-1:0]     s_channel_1 = '0;
    logic [CHAN_W-1:0]     s_channel_2 = '0;
    logic [CHAN_W-1:0]     s_channel_3 = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_avg_0;
    logic [CHAN_W-1:0]     m_avg_1;
    logic [CHAN_W-1:0]     m_avg_2;
    logic [CHAN_W-1:0]     m_avg_3;
    logic                  m_last_of_frame;

    rgba_downscale_by_two_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_0     (s_channel_0),
        .s_channel_1     (s_channel_1),
        .s_channel_2     (s_channel_2),
        .s_channel_3     (s_channel_3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_avg_0         (m_avg_0),
        .m_avg_1         (m_avg_1),
        .m_avg_2         (m_avg_2),
        .m_avg_3         (m_avg_3),
        .m_last_of_frame (m_last_of_frame)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic [WIDTH_W-1:0]          frame_w_reg = WIDTH_RESET;
    logic [ROW_W-1:0]            frame_h_reg = HEIGHT_RESET;
    logic [3:0][PAIR_W-1:0]      pair_line [LINE_DEPTH];
    pixel_t                      held_px = '0;
    int                          col_pos = 0;
    int                          row_pos = 0;
    block_avg_t                  block_avg_q[$];

    // stimulus and bookkeeping
    pixel_t     pixel_q[$];
    int         pixels_queued = 0;
    int         pixels_taken = 0;
    int         avgs_predicted = 0;
    int         avgs_checked = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         req_taken = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         holds_asked = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    int         mode_left = 0;
    rx_mode_t   rx_mode = RX_STREAM;
    pixel_t     next_px;
    pixel_t     got_avg;
    block_avg_t want;

    function automatic int eff_width();
        if (frame_w_reg == 0) return 1;
        if (frame_w_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(frame_w_reg);
    endfunction

    function automatic int eff_height();
        if (frame_h_reg == 0) return 1;
        return int'(frame_h_reg);
    endfunction

    task automatic downscale_pixel(input pixel_t px);
        int                     w;
        int                     h;
        int                     slot;
        logic [3:0][PAIR_W-1:0] pair;
        logic [PAIR_W:0]        block_sum;
        block_avg_t             r;
        w = eff_width();
        h = eff_height();
        if (col_pos[0] == 1'b0) begin
            held_px = px;
        end else begin
            slot = col_pos >> 1;
            for (int c = 0; c < 4; c++)
                pair[c] = PAIR_W'(held_px[c]) + PAIR_W'(px[c]);
            if (row_pos[0] == 1'b0) begin
                pair_line[slot] = pair;
            end else begin
                for (int c = 0; c < 4; c++) begin
                    block_sum = {1'b0, pair_line[slot][c]} + {1'b0, pair[c]};
                    r.avg[c] = block_sum[PAIR_W:2];
                end
                r.last = (col_pos == 2 * (w / 2) - 1) && (row_pos == 2 * (h / 2) - 1);
                block_avg_q = {block_avg_q, r};
                avgs_predicted++;
            end
        end
        // a position at or past the last one wraps on this advance
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // sample, predict and check at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            req_taken = s_valid && s_ready;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_w_reg = cfg_wdata[WIDTH_W-1:0];
                    CFG_FRAME_HEIGHT: frame_h_reg = cfg_wdata[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (req_taken) begin
                downscale_pixel({s_channel_3, s_channel_2, s_channel_1, s_channel_0});
                pixels_taken++;
            end
            if (m_valid && m_ready) begin
                got_avg = {m_avg_3, m_avg_2, m_avg_1, m_avg_0};
                if (block_avg_q.size() == 0) begin
                    $display("%0t: unexpected result avg=%h last=%b", $time, got_avg,
                             m_last_of_frame);
                    mismatches++;
                end else begin
                    want = block_avg_q.pop_front();
                    avgs_checked++;
                    for (int c = 0; c < 4; c++) begin
                        if (got_avg[c] !== want.avg[c]) begin
                            $display("%0t: avg_%0d expected %0d, got %0d", $time, c,
                                     want.avg[c], got_avg[c]);
                            mismatches++;
                        end
                    end
                    if (m_last_of_frame !== want.last) begin
                        $display("%0t: last_of_frame expected %b, got %b", $time,
                                 want.last, m_last_of_frame);
                        mismatches++;
                    end
                end
            end
            if (req_taken || (m_valid && m_ready) || cfg_we) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // pixel sender: bursts of random length with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                next_px = pixel_q.pop_front();
                s_valid <= 1'b1;
                s_channel_0 <= next_px[0];
                s_channel_1 <= next_px[1];
                s_channel_2 <= next_px[2];
                s_channel_3 <= next_px[3];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern of its own, plus long hold-offs on request
    always @(negedge aclk) begin
        if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_STREAM:  m_ready <= 1'b1;
                RX_COIN:    m_ready <= ($urandom_range(0, 1) == 1);
                RX_PATTERN: m_ready <= (mode_left % 3 != 0);
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    task automatic offer(input pixel_t px);
        pixel_q = {pixel_q, px};
        pixels_queued++;
    endtask

    function automatic pixel_t any_pixel();
        pixel_t px;
        for (int c = 0; c < 4; c++)
            px[c] = ($urandom_range(0, 7) == 0) ? {CHAN_W{$urandom_range(0, 1) == 1}}
                                                : CHAN_W'($urandom);
        return px;
    endfunction

    task automatic offer_random(input int count);
        for (int i = 0; i < count; i++)
            offer(any_pixel());
    endtask

    // wait until every pixel is taken and every average has arrived
    task automatic settle();
        wait (pixels_taken == pixels_queued && avgs_checked == avgs_predicted);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int phase;
        int w;
        int h;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // one 4x2 frame: extremes and mixed channels
        set_frame(16'd4, 16'd2);
        offer({4{8'h00}});
        offer({4{8'hFF}});
        offer({4{8'hFF}});
        offer({8'h01, 8'h80, 8'h7F, 8'hFE});
        offer({4{8'hFF}});
        offer({8'h00, 8'hFF, 8'h00, 8'hFF});
        offer({4{8'hFF}});
        offer({4{8'hFF}});
        settle();

        // shrink the width mid-frame with the column already past the new end
        write_reg(CFG_FRAME_HEIGHT, 16'd4);
        offer_random(14);
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'd2);
        offer_random(1);
        settle();

        // zero width and zero height count as one: no output
        set_frame(16'd0, 16'd2);
        offer_random(2);
        settle();
        set_frame(16'd3, 16'd0);
        offer_random(3);
        settle();

        phase = 0;
        while (pixels_queued < 850) begin
            if (phase == 3) begin
                // stall the receiver long enough to back up the input
                set_frame(16'd16, 16'd8);
                holds_asked++;
                offer_random(128);
            end else if (phase == 6) begin
                // tallest frame, then cut the height with the row past its end
                w = 2 * $urandom_range(1, 8);
                set_frame(CFG_DATA_W'(w), 16'hFFFF);
                offer_random(6 * w);
                settle();
                write_reg(CFG_FRAME_HEIGHT, 16'd3);
                offer_random(w);
            end else if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    set_frame(CFG_DATA_W'($urandom_range(0, 1)),
                              CFG_DATA_W'($urandom_range(1, 6)));
                else
                    set_frame(CFG_DATA_W'($urandom_range(2, 24)),
                              CFG_DATA_W'($urandom_range(0, 1)));
                offer_random(eff_width() * eff_height() * $urandom_range(1, 3));
            end else begin
                w = $urandom_range(2, 24);
                h = $urandom_range(2, 8);
                set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
                offer_random(eff_width() * eff_height() * $urandom_range(1, 3));
            end
            settle();
            phase++;
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
